// File: rtl/nfss_pkg.sv
package nfss_pkg;

    // Width of a request; a result needs one more bit to reach 2^REQUEST_WIDTH.
    localparam int REQUEST_WIDTH = 16;
    localparam int VAL_W         = REQUEST_WIDTH + 1;

    // Exact division by 3 and 5 through a multiply by a rounded-up reciprocal.
    // With the shift three bits past the value width the quotient is exact.
    localparam int DIV_SHIFT = VAL_W + 3;
    localparam int RECIP_W   = VAL_W + 2;
    localparam int PROD_W    = VAL_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP3 =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3);
    localparam logic [RECIP_W-1:0] RECIP5 =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd4) / 64'd5);

    typedef enum logic [1:0] {
        PR_TWO,
        PR_THREE,
        PR_FIVE
    } prime_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } nfss_cmd_t;

    typedef struct packed {
        logic found;
    } nfss_status_t;

endpackage

// File: rtl/nfss_datapath.sv
module nfss_datapath
    import nfss_pkg::*;
(
    input  logic                     clk,
    input  nfss_cmd_t                cmd,
    output nfss_status_t             status,
    input  logic [REQUEST_WIDTH-1:0] request_size,
    output logic [VAL_W-1:0]         smooth_size
);

    logic [VAL_W-1:0]   cand_reg, cand_next;
    logic [VAL_W-1:0]   rest_reg, rest_next;
    prime_t             prime_reg, prime_next;
    logic [VAL_W-1:0]   smooth_reg, smooth_next;

    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  product;
    logic [VAL_W-1:0]   quot_odd;
    logic [VAL_W-1:0]   back;
    logic [VAL_W-1:0]   quotient;
    logic [VAL_W-1:0]   start;
    logic [VAL_W-1:0]   cand_inc;
    logic               divisible;
    logic               last_prime;

    // Trial division of the remaining cofactor by the current prime.
    always_comb
    begin
        recip    = (prime_reg == PR_THREE) ? RECIP3 : RECIP5;
        product  = PROD_W'(rest_reg) * PROD_W'(recip);
        quot_odd = {1'b0, product[PROD_W-1:DIV_SHIFT]};
        if (prime_reg == PR_THREE)
        begin
            back = quot_odd + {quot_odd[VAL_W-2:0], 1'b0};
        end
        else
        begin
            back = quot_odd + {quot_odd[VAL_W-3:0], 2'b00};
        end
        case (prime_reg)
            PR_TWO:
            begin
                divisible = ~rest_reg[0];
                quotient  = rest_reg >> 1;
            end
            PR_THREE, PR_FIVE:
            begin
                divisible = (back == rest_reg);
                quotient  = quot_odd;
            end
            default:
            begin
                divisible = 1'b0;
                quotient  = rest_reg;
            end
        endcase
        last_prime   = (prime_reg == PR_FIVE);
        status.found = last_prime && !divisible && (rest_reg == VAL_W'(1));
        start        = (request_size <= REQUEST_WIDTH'(1)) ? VAL_W'(1)
                                                           : {1'b0, request_size};
        cand_inc     = cand_reg + VAL_W'(1);
    end

    always_comb
    begin
        cand_next   = cand_reg;
        rest_next   = rest_reg;
        prime_next  = prime_reg;
        smooth_next = smooth_reg;
        if (cmd.load)
        begin
            cand_next  = start;
            rest_next  = start;
            prime_next = PR_TWO;
        end
        else if (cmd.step)
        begin
            if (divisible)
            begin
                rest_next = quotient;
            end
            else if (!last_prime)
            begin
                prime_next = (prime_reg == PR_TWO) ? PR_THREE : PR_FIVE;
            end
            else
            begin
                // Cofactor left over: advance to the next candidate.
                cand_next  = cand_inc;
                rest_next  = cand_inc;
                prime_next = PR_TWO;
            end
        end
        if (cmd.publish)
        begin
            smooth_next = cand_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg   <= cand_next;
        rest_reg   <= rest_next;
        prime_reg  <= prime_next;
        smooth_reg <= smooth_next;
    end

    assign smooth_size = smooth_reg;

endmodule

// File: rtl/nfss_ctrl.sv
module nfss_ctrl
    import nfss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  nfss_status_t status,
    output nfss_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_full_reg, out_full_next;
    logic   slot_free;

    assign slot_free = !out_full_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (status.found && slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SEARCH:
            begin
                if (status.found)
                begin
                    cmd.publish = slot_free;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.publish)
        begin
            out_full_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_full_next = 1'b0;
        end
        else
        begin
            out_full_next = out_full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

    assign out_valid = out_full_reg;

    a_publish_found : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (status.found && state_reg == ST_SEARCH))
        else $error("result published before search finished");

    a_publish_valid : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> (out_valid && state_reg == ST_IDLE))
        else $error("published result not presented");

    a_search_steps : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH && !status.found) |-> cmd.step)
        else $error("search stalled without a result");

    a_load_search : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_SEARCH))
        else $error("accepted request not searched");

endmodule

// File: rtl/next_five_smooth_size.sv
// Throughput: one request at a time; the search loop over candidates in the
// single-step trial-division datapath (one divide per cycle) sets the rate.
// A finished result waits in an output register while the next request is taken.
// Reset (rst_n, asynchronous, active low) clears the controller and output valid.
module next_five_smooth_size
    import nfss_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [REQUEST_WIDTH-1:0] request_size,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [VAL_W-1:0]         smooth_size
);

    // Command and status between the sequencer and the trial-division datapath.
    nfss_cmd_t    cmd;
    nfss_status_t status;

    // The controller accepts a transaction in idle, issues one trial-division step
    // per cycle while searching, and publishes the result into the output
    // register once the datapath flags a 5-smooth candidate and the slot is free.
    nfss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the candidate, its remaining cofactor and the current
    // prime; each step divides the cofactor by the prime or moves on, and steps
    // to the next candidate when a cofactor other than one is left after five.
    nfss_datapath u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .status       (status),
        .request_size (request_size),
        .smooth_size  (smooth_size)
    );

endmodule

// File: tb/smooth_size_checker.sv
module smooth_size_checker
    import nfss_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [REQUEST_WIDTH-1:0] request_size,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [VAL_W-1:0]         smooth_size,
    output int                       mismatches,
    output int                       sizes_outstanding
);

    typedef struct packed {
        logic [REQUEST_WIDTH-1:0] request;
        logic [VAL_W-1:0]         size;
    } sized_request_t;

    sized_request_t sizes_due [$];
    int             errors = 0;

    // Smallest value at or above the request with no prime factor beyond 5.
    function automatic logic [VAL_W-1:0] next_smooth(input logic [REQUEST_WIDTH-1:0] request);
        int unsigned candidate;
        int unsigned rest;
        candidate = (request <= 1) ? 1 : int'(request);
        forever
        begin
            rest = candidate;
            while (rest % 2 == 0)
                rest = rest / 2;
            while (rest % 3 == 0)
                rest = rest / 3;
            while (rest % 5 == 0)
                rest = rest / 5;
            if (rest == 1)
                break;
            candidate++;
        end
        return VAL_W'(candidate);
    endfunction

    always @(posedge clk)
    begin
        sized_request_t due;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sizes_due.push_back('{request: request_size, size: next_smooth(request_size)});
            if (out_valid && out_ready)
            begin
                if (sizes_due.size() == 0)
                begin
                    $display("%0t: unexpected smooth_size %0d with no request outstanding",
                             $time, smooth_size);
                    errors++;
                end
                else
                begin
                    due = sizes_due.pop_front();
                    if (smooth_size !== due.size)
                    begin
                        $display("%0t: smooth_size for request %0d: expected %0d, actual %0d",
                                 $time, due.request, due.size, smooth_size);
                        errors++;
                    end
                end
            end
        end
        mismatches        <= errors;
        sizes_outstanding <= sizes_due.size();
    end

endmodule

// File: tb/tb_next_five_smooth_size.sv
module tb_next_five_smooth_size;
    import nfss_pkg::*;

    localparam int RANDOM_REQUESTS = 68;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 50;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     in_valid     = 1'b0;
    logic                     in_ready;
    logic [REQUEST_WIDTH-1:0] request_size = '0;
    logic                     out_valid;
    logic                     out_ready    = 1'b0;
    logic [VAL_W-1:0]         smooth_size;

    int mismatches;
    int sizes_outstanding;

    // Shared between the request and result sides: steady suppresses idling
    // on both, hold_request asks the result side for one long back-pressure.
    logic steady       = 1'b0;
    logic hold_request = 1'b0;

    // Corner requests: zero and one, small primes that force a step,
    // exact powers, the wide gaps just past 62500 and 64800, the top of
    // the range (65535 -> 65536) and alternating bit patterns.
    logic [REQUEST_WIDTH-1:0] corner_requests [$] = '{
        16'd0,     16'd1,     16'd2,     16'd3,     16'd4,     16'd5,
        16'd6,     16'd7,     16'd8,     16'd11,    16'd13,    16'd4097,
        16'd59049, 16'd59050, 16'd62500, 16'd62501, 16'd64801, 16'd65534,
        16'd65535, 16'h5555,  16'hAAAA,  16'h8000,  16'h7FFF,  16'd1000
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    next_five_smooth_size dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .request_size (request_size),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .smooth_size  (smooth_size)
    );

    smooth_size_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .request_size      (request_size),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .smooth_size       (smooth_size),
        .mismatches        (mismatches),
        .sizes_outstanding (sizes_outstanding)
    );

    // Offer one request; return at the edge where the transaction completes,
    // so the next call can keep valid high without a gap.
    task automatic offer_request(input logic [REQUEST_WIDTH-1:0] value);
        while (!steady && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        request_size <= value;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid and hold the request side until every result is back.
    // Wait first until the registered outstanding count includes the last request.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sizes_outstanding != 0)
            @(posedge clk);
    endtask

    // Search time grows with the request, so keep most random requests small
    // and only a few across the full 16-bit range.
    function automatic logic [REQUEST_WIDTH-1:0] random_request();
        int unsigned band;
        band = $urandom_range(99);
        if (band < 55)
            return REQUEST_WIDTH'($urandom_range(1023));
        else if (band < 85)
            return REQUEST_WIDTH'($urandom_range(16383));
        return REQUEST_WIDTH'($urandom_range(65535));
    endfunction

    // Request side: reset, corner cases, a full drain, a burst against a
    // stalled output, then the random run with a stretch of steady traffic.
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_requests[i])
            offer_request(corner_requests[i]);

        // Pause the request side until the block has answered everything.
        drain_results();

        // Fill the block while the result side holds off; keep offering so the
        // input stalls behind the parked result.
        hold_request = 1'b1;
        steady       = 1'b1;
        repeat (8)
            offer_request(REQUEST_WIDTH'($urandom_range(64)));
        steady = 1'b0;

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            steady = (n >= 30 && n < 50);
            offer_request(random_request());
        end
        steady = 1'b0;

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && sizes_outstanding == 0)
            $display("** next_five_smooth_size: PASSED **");
        else
            $display("** next_five_smooth_size: FAILED **");
        $finish;
    end

    // Result side: random back-pressure, none while steady, and one long
    // hold-off counted here when the request side asks for it.
    initial
    begin
        logic hold_done;
        hold_done = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_request && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            out_ready <= steady || ($urandom_range(99) >= 28);
            @(posedge clk);
        end
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #60_000_000;
        $display("** next_five_smooth_size: FAILED **");
        $finish;
    end

endmodule
